>>> hdl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// ASSERT_CLK checks a property on every rising clock edge outside reset.
// ASSERT_NEVER checks that a condition never holds outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

>>> hdl/msbg_pkg.sv
package msbg_pkg;

  // Sample and control field widths
  localparam int SAMPLE_W  = 32;
  localparam int ALIGN_W   = 5;
  localparam int ESHIFT_W  = 5;
  localparam int COEF_W    = 8;
  localparam int ENERGY_W  = 64;
  localparam int PROD_W    = ENERGY_W + COEF_W;
  localparam int BANDNUM_W = 6;

  // Default band count
  localparam int BANDS_DEF = 32;

  // Input beat layout
  localparam int S_TDATA_W = 80;
  localparam int L_SMP_LO  = 0;
  localparam int R_SMP_LO  = L_SMP_LO + SAMPLE_W;
  localparam int L_AL_LO   = R_SMP_LO + SAMPLE_W;
  localparam int R_AL_LO   = L_AL_LO + ALIGN_W;
  localparam int BEND_BIT  = R_AL_LO + ALIGN_W;

  // Output beat layout
  localparam int M_TDATA_W = 8;

  // Configuration port
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 8;

  localparam logic [CFG_IW-1:0] REG_ENERGY_SHIFT = 3'd0;
  localparam logic [CFG_IW-1:0] REG_ENTER_NUM    = 3'd1;
  localparam logic [CFG_IW-1:0] REG_ENTER_DEN    = 3'd2;
  localparam logic [CFG_IW-1:0] REG_EXIT_NUM     = 3'd3;
  localparam logic [CFG_IW-1:0] REG_EXIT_DEN     = 3'd4;

  localparam logic [ESHIFT_W-1:0] ENERGY_SHIFT_RST = 5'd7;
  localparam logic [COEF_W-1:0]   ENTER_NUM_RST    = 8'd1;
  localparam logic [COEF_W-1:0]   ENTER_DEN_RST    = 8'd4;
  localparam logic [COEF_W-1:0]   EXIT_NUM_RST     = 8'd13;
  localparam logic [COEF_W-1:0]   EXIT_DEN_RST     = 8'd32;

  // Register file contents
  typedef struct packed {
    logic [ESHIFT_W-1:0] energy_shift;
    logic [COEF_W-1:0]   enter_num;
    logic [COEF_W-1:0]   enter_den;
    logic [COEF_W-1:0]   exit_num;
    logic [COEF_W-1:0]   exit_den;
  } cfg_t;

  // Band energies handed to the decision stage
  typedef struct packed {
    logic [ENERGY_W-1:0] mid;
    logic [ENERGY_W-1:0] side;
    logic                frame_end;
  } totals_t;

endpackage

>>> hdl/mid_side_band_gate.sv
// Mid/side stereo decision per band. Each input beat carries one left/right
// coefficient pair with per-channel alignment shifts; mid and side energies
// are summed per band and, at each band close (band_end or the frame-closing
// tlast), one result beat reports the band's hysteresis flag, and on the
// frame's last band also whether any band of the frame was flagged. The block
// takes one beat per clock unless stalled. The only feedback between beats is
// the 64-bit accumulate, so input and output sides are parted by a pipeline
// of five registered stages and a result register: the input stalls only
// when a result is held and closed bands fill the stages behind it. Flags
// persist across frames and start cleared after reset; configuration writes
// are taken in any cycle and must land while no beat is in flight.
module mid_side_band_gate
  import msbg_pkg::*;
#(
  parameter int BANDS = BANDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // left_sample, right_sample, left_align, right_align, band_end, zero pad
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 s_tlast,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // band_number, band_on, frame_any
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic                 m_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IW-1:0]    cfg_index,
  input  logic [CFG_DW-1:0]    cfg_data
);

  cfg_t    cfg;
  totals_t tot;
  logic    tot_valid, tot_ready;

  msbg_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  msbg_energy u_energy (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tlast      (s_tlast),
    .energy_shift (cfg.energy_shift),
    .tot_valid    (tot_valid),
    .tot_ready    (tot_ready),
    .tot          (tot)
  );

  msbg_decide #(
    .BANDS (BANDS)
  ) u_decide (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .tot_valid (tot_valid),
    .tot_ready (tot_ready),
    .tot       (tot),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

>>> hdl/msbg_cfg.sv
module msbg_cfg
  import msbg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  output cfg_t              cfg
);

  // Writes are always taken
  assign cfg_ready = 1'b1;

  // Update the addressed register; drop writes to unused indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.energy_shift <= ENERGY_SHIFT_RST;
      cfg.enter_num    <= ENTER_NUM_RST;
      cfg.enter_den    <= ENTER_DEN_RST;
      cfg.exit_num     <= EXIT_NUM_RST;
      cfg.exit_den     <= EXIT_DEN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ENERGY_SHIFT: cfg.energy_shift <= cfg_data[ESHIFT_W-1:0];
        REG_ENTER_NUM:    cfg.enter_num    <= cfg_data;
        REG_ENTER_DEN:    cfg.enter_den    <= cfg_data;
        REG_EXIT_NUM:     cfg.exit_num     <= cfg_data;
        REG_EXIT_DEN:     cfg.exit_den     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/msbg_energy.sv
`include "assert_macros.svh"

module msbg_energy
  import msbg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // left_sample, right_sample, left_align, right_align, band_end, zero pad
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 s_tlast,
  input  logic [ESHIFT_W-1:0]  energy_shift,
  output logic                 tot_valid,
  input  logic                 tot_ready,
  output totals_t              tot
);

  // Stage 1: captured beat
  logic                       v1;
  logic signed [SAMPLE_W-1:0] l_smp, r_smp;
  logic [ALIGN_W-1:0]         l_al, r_al;
  logic                       close1, fend1;

  // Stage 2: mid and side samples
  logic                     v2;
  logic signed [SAMPLE_W:0] m2, s2;
  logic                     close2, fend2;

  // Stage 3: squares
  logic                v3;
  logic [ENERGY_W-1:0] msq, ssq;
  logic                close3, fend3;

  // Accumulators
  logic [ENERGY_W-1:0] mid_sum, side_sum;
  logic [ENERGY_W-1:0] mid_sum_next, side_sum_next;

  logic acc1, go1, go2, go3, free1, free2, free3;
  logic signed [SAMPLE_W-1:0] l_sh, r_sh;
  logic signed [2*SAMPLE_W+1:0] m_prod, s_prod;

  // Advance each stage when the one after it has room
  always_comb begin
    go3   = v3 && (!close3 || !tot_valid || tot_ready);
    free3 = !v3 || go3;
    go2   = v2 && free3;
    free2 = !v2 || free3;
    go1   = v1 && free2;
    free1 = !v1 || free2;
  end

  assign s_tready = free1;
  assign acc1     = s_tvalid && s_tready;

  // Align and energy shift; the butterfly is taken into stage 2
  always_comb begin
    l_sh = (l_smp >>> l_al) >>> energy_shift;
    r_sh = (r_smp >>> r_al) >>> energy_shift;
  end

  // Squares, modulo the accumulator width
  assign m_prod = m2 * m2;
  assign s_prod = s2 * s2;

  assign mid_sum_next  = mid_sum + msq;
  assign side_sum_next = side_sum + ssq;

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      tot_valid <= 1'b0;
    end else begin
      v1        <= acc1 || (v1 && !go1);
      v2        <= go1 || (v2 && !go2);
      v3        <= go2 || (v3 && !go3);
      tot_valid <= (go3 && close3) || (tot_valid && !tot_ready);
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (acc1) begin
      l_smp  <= $signed(s_tdata[L_SMP_LO +: SAMPLE_W]);
      r_smp  <= $signed(s_tdata[R_SMP_LO +: SAMPLE_W]);
      l_al   <= s_tdata[L_AL_LO +: ALIGN_W];
      r_al   <= s_tdata[R_AL_LO +: ALIGN_W];
      close1 <= s_tdata[BEND_BIT] || s_tlast;
      fend1  <= s_tlast;
    end
    if (go1) begin
      m2     <= {l_sh[SAMPLE_W-1], l_sh} + {r_sh[SAMPLE_W-1], r_sh};
      s2     <= {l_sh[SAMPLE_W-1], l_sh} - {r_sh[SAMPLE_W-1], r_sh};
      close2 <= close1;
      fend2  <= fend1;
    end
    if (go2) begin
      msq    <= m_prod[ENERGY_W-1:0];
      ssq    <= s_prod[ENERGY_W-1:0];
      close3 <= close2;
      fend3  <= fend2;
    end
    if (go3 && close3) begin
      tot.mid       <= mid_sum_next;
      tot.side      <= side_sum_next;
      tot.frame_end <= fend3;
    end
  end

  // Accumulate; restart the energies when a band closes
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_sum  <= '0;
      side_sum <= '0;
    end else if (go3) begin
      if (close3) begin
        mid_sum  <= '0;
        side_sum <= '0;
      end else begin
        mid_sum  <= mid_sum_next;
        side_sum <= side_sum_next;
      end
    end
  end

  `ASSERT_CLK(a_sum_restart, clk, rst, go3 && close3 |=> mid_sum == '0 && side_sum == '0, "energies not restarted after band close")
  `ASSERT_CLK(a_no_loss, clk, rst, go2 |=> v3, "square stage lost a beat")
  `ASSERT_CLK(a_open_band_flows, clk, rst, v3 && !close3 |-> go3, "open-band beat stalled at accumulator")

endmodule

>>> hdl/msbg_decide.sv
`include "assert_macros.svh"

module msbg_decide
  import msbg_pkg::*;
#(
  parameter int BANDS = BANDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  logic                 tot_valid,
  output logic                 tot_ready,
  input  totals_t              tot,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // band_number, band_on, frame_any
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic                 m_tlast
);

  localparam int BIW = (BANDS > 1) ? $clog2(BANDS) : 1;

  // Product stage
  logic              v5;
  logic [PROD_W-1:0] p_sde, p_mne, p_mxn, p_sxd;
  logic              mid_zero, fend5;

  // Band state
  logic [BIW-1:0]   band_counter;
  logic [BANDS-1:0] band_flags;
  logic             any_seen;

  // Result register
  logic [BANDNUM_W-1:0] out_band;
  logic                 out_on, out_any, out_last;

  logic out_free, mv4, mv5;
  logic flag_cur, flag_next, any_next;
  logic [BIW-1:0] band_counter_next;

  assign out_free  = !m_tvalid || m_tready;
  assign mv5       = v5 && out_free;
  assign tot_ready = !v5 || out_free;
  assign mv4       = tot_valid && tot_ready;

  // Hysteresis update of the current band's flag; next frame summary and band counter
  always_comb begin
    flag_cur = band_flags[band_counter];
    if (mid_zero) begin
      flag_next = 1'b0;
    end else if (p_sde < p_mne) begin
      flag_next = 1'b1;
    end else if (p_mxn < p_sxd) begin
      flag_next = 1'b0;
    end else begin
      flag_next = flag_cur;
    end
    any_next = any_seen || flag_next;
    if (fend5 || band_counter == BIW'(BANDS - 1)) begin
      band_counter_next = '0;
    end else begin
      band_counter_next = band_counter + 1'b1;
    end
  end

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v5       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      v5 <= mv4 || (v5 && !mv5);
      if (mv5) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Scale both energies by the ratio terms
  always_ff @(posedge clk) begin
    if (mv4) begin
      p_sde    <= PROD_W'(tot.side) * PROD_W'(cfg.enter_den);
      p_mne    <= PROD_W'(tot.mid) * PROD_W'(cfg.enter_num);
      p_mxn    <= PROD_W'(tot.mid) * PROD_W'(cfg.exit_num);
      p_sxd    <= PROD_W'(tot.side) * PROD_W'(cfg.exit_den);
      mid_zero <= (tot.mid == '0);
      fend5    <= tot.frame_end;
    end
  end

  // Load the result
  always_ff @(posedge clk) begin
    if (mv5) begin
      out_band <= BANDNUM_W'(band_counter);
      out_on   <= flag_next;
      out_any  <= fend5 && any_next;
      out_last <= fend5;
    end
  end

  // Band counter, flags and frame summary
  always_ff @(posedge clk) begin
    if (rst) begin
      band_counter <= '0;
      band_flags   <= '0;
      any_seen     <= 1'b0;
    end else if (mv5) begin
      band_counter             <= band_counter_next;
      band_flags[band_counter] <= flag_next;
      any_seen                 <= fend5 ? 1'b0 : any_next;
    end
  end

  assign m_tdata = {out_any, out_on, out_band};
  assign m_tlast = out_last;

  `ASSERT_CLK(a_any_at_frame_end, clk, rst, m_tvalid && out_any |-> out_last, "frame_any set on a result that does not close the frame")
  `ASSERT_CLK(a_band_range, clk, rst, band_counter <= BIW'(BANDS - 1), "band counter out of range")
  `ASSERT_CLK(a_frame_restart, clk, rst, mv5 && fend5 |=> band_counter == '0 && !any_seen, "frame state not restarted")

endmodule
